// ===== src/utd_pkg.sv =====
package utd_pkg;

   localparam int CountBitsDefault = 24;
   localparam int FieldCountBits   = 24;
   localparam int CodeBits         = 21;
   localparam int MaxResults       = 3;
   localparam int QueueDepth       = 4;
   localparam int QueuePtrBits     = $clog2(QueueDepth);
   localparam int QueueCntBits     = $clog2(QueueDepth + 1);
   localparam int RspDataBits      = 72;
   localparam int WideBits         = 49;
   localparam int CsrAddrBits      = 4;

   localparam logic [1:0] RegSixteenBitUnits = 2'd0;
   localparam logic [1:0] RegCountOnly       = 2'd1;
   localparam logic [1:0] RegUnitCapacity    = 2'd2;

   localparam logic [CodeBits-1:0] MaxCodePoint  = 21'h10FFFF;
   localparam logic [CodeBits-1:0] SurrogateLow  = 21'h00D800;
   localparam logic [CodeBits-1:0] SurrogateEnd  = 21'h00E000;
   localparam logic [CodeBits-1:0] LowSurrogate  = 21'h00DC00;
   localparam logic [CodeBits-1:0] Supplementary = 21'h010000;

   typedef enum logic [1:0] {
      KIND_UNIT    = 2'd0,
      KIND_OK      = 2'd1,
      KIND_INVALID = 2'd2
   } kind_type;

   typedef struct packed {
      logic        sixteen_bit_units;
      logic        count_only;
      logic [23:0] unit_capacity;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          bytes_remaining;
      logic [2:0]          sequence_length;
      logic [7:0]          lead_byte;
      logic [CodeBits-1:0] partial_code_point;
      logic                stopped_flag;
      logic                error_flag;
   } str_state_type;

   typedef struct packed {
      kind_type                  kind;
      logic [CodeBits-1:0]       code_unit;
      logic [FieldCountBits-1:0] bytes_read;
      logic [FieldCountBits-1:0] units_written;
      logic                      last;
   } rsp_entry_type;

endpackage

// ===== src/utf8_to_wide_decoder_core.sv =====
// UTF-8 to code point / UTF-16 decoder.
// Results of an input beat are written into the registered result queue and offered from its head in order.
// Throughput: one input byte per cycle; a byte that yields a surrogate pair plus
// a status needs three output beats, and the four-entry result queue stalls input
// while more than one beat is queued.
// Reset (synchronous): clears the string state and the queue, loads register defaults.
module utf8_to_wide_decoder_core
   import utd_pkg::*;
#(
   parameter int COUNT_BITS = CountBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // data_byte
   input  logic                   req_tuser,  // byte_valid
   input  logic                   req_tlast,  // end_of_string
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,  // code_unit, bytes_read, units_written, pad
   output logic [1:0]             rsp_tuser,  // kind
   output logic                   rsp_tlast,  // last
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CsrAddrBits-1:0] csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   str_state_type           st_ff;
   str_state_type           st_in;
   logic [COUNT_BITS-1:0]   read_cnt_ff;
   logic [COUNT_BITS-1:0]   read_cnt_in;
   logic [COUNT_BITS-1:0]   written_cnt_ff;
   logic [COUNT_BITS-1:0]   written_cnt_in;
   logic [1:0]              rsp_cnt;
   rsp_entry_type           step_rsp [MaxResults];
   logic [1:0]              push_cnt;
   logic [QueueCntBits-1:0] q_count;
   rsp_entry_type           head;
   logic                    req_fire;
   logic                    csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            RegSixteenBitUnits: cfg_in.sixteen_bit_units = csr_pwdata[0];
            RegCountOnly:       cfg_in.count_only        = csr_pwdata[0];
            RegUnitCapacity:    cfg_in.unit_capacity     = csr_pwdata[23:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         RegSixteenBitUnits: csr_prdata = 32'(cfg_ff.sixteen_bit_units);
         RegCountOnly:       csr_prdata = 32'(cfg_ff.count_only);
         RegUnitCapacity:    csr_prdata = 32'(cfg_ff.unit_capacity);
         default:            csr_prdata = '0;
      endcase
   end

   // room for a worst-case beat group must be free
   assign req_tready = (q_count <= QueueCntBits'(QueueDepth - MaxResults));
   assign req_fire   = req_tvalid && req_tready;
   assign push_cnt   = req_fire ? rsp_cnt : 2'd0;

   utd_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .cfg_i          (cfg_ff),
      .st_i           (st_ff),
      .read_cnt_i     (read_cnt_ff),
      .written_cnt_i  (written_cnt_ff),
      .data_byte_i    (req_tdata),
      .byte_valid_i   (req_tuser),
      .end_of_string_i(req_tlast),
      .st_o           (st_in),
      .read_cnt_o     (read_cnt_in),
      .written_cnt_o  (written_cnt_in),
      .rsp_cnt_o      (rsp_cnt),
      .rsp_o          (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= '{sixteen_bit_units: 1'b1, count_only: 1'b0, unit_capacity: '1};
         st_ff          <= '0;
         read_cnt_ff    <= '0;
         written_cnt_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_fire) begin
            st_ff          <= st_in;
            read_cnt_ff    <= read_cnt_in;
            written_cnt_ff <= written_cnt_in;
         end
      end
   end

   utd_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_cnt_i(push_cnt),
      .push_i    (step_rsp),
      .pop_i     (rsp_tvalid && rsp_tready),
      .count_o   (q_count),
      .head_o    (head)
   );

   assign rsp_tvalid = (q_count != '0);
   assign rsp_tdata  = RspDataBits'({head.units_written, head.bytes_read, head.code_unit});
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

endmodule

// ===== src/utd_step.sv =====
module utd_step
   import utd_pkg::*;
#(
   parameter int COUNT_BITS = CountBitsDefault
) (
   input  cfg_type               cfg_i,
   input  str_state_type         st_i,
   input  logic [COUNT_BITS-1:0] read_cnt_i,
   input  logic [COUNT_BITS-1:0] written_cnt_i,
   input  logic [7:0]            data_byte_i,
   input  logic                  byte_valid_i,
   input  logic                  end_of_string_i,
   output str_state_type         st_o,
   output logic [COUNT_BITS-1:0] read_cnt_o,
   output logic [COUNT_BITS-1:0] written_cnt_o,
   output logic [1:0]            rsp_cnt_o,
   output rsp_entry_type         rsp_o [MaxResults]
);

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                     input logic [2:0] b);
      logic [COUNT_BITS:0] s;
      s = (COUNT_BITS + 1)'(a) + (COUNT_BITS + 1)'(b);
      return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
   endfunction

   logic                  finish;
   logic [CodeBits-1:0]   cp;
   logic [CodeBits-1:0]   sup;
   logic [1:0]            units;
   logic [1:0]            n;
   logic [7:0]            b;
   logic [WideBits-1:0]   rd_wide;
   logic [WideBits-1:0]   wr_wide;

   assign b = data_byte_i;

   always_comb begin
      st_o          = st_i;
      read_cnt_o    = read_cnt_i;
      written_cnt_o = written_cnt_i;
      finish        = 1'b0;
      n             = 2'd0;
      cp            = '0;
      sup           = '0;
      units         = 2'd1;
      rd_wide       = '0;
      wr_wide       = '0;
      for (int i = 0; i < MaxResults; i++) begin
         rsp_o[i] = '0;
      end

      if (byte_valid_i && !st_i.error_flag && !st_i.stopped_flag) begin
         if (st_i.bytes_remaining == 2'd0) begin
            st_o.lead_byte = b;
            if (!b[7]) begin
               st_o.sequence_length    = 3'd1;
               st_o.partial_code_point = CodeBits'(b);
               finish                  = 1'b1;
            end else if (b[7:5] == 3'b110) begin
               // lead C0 or C1 can only encode an overlong form
               if (b[4:1] == 4'd0) begin
                  st_o.error_flag = 1'b1;
               end else begin
                  st_o.sequence_length    = 3'd2;
                  st_o.partial_code_point = CodeBits'(b[4:0]);
                  st_o.bytes_remaining    = 2'd1;
               end
            end else if (b[7:4] == 4'b1110) begin
               st_o.sequence_length    = 3'd3;
               st_o.partial_code_point = CodeBits'(b[3:0]);
               st_o.bytes_remaining    = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               st_o.sequence_length    = 3'd4;
               st_o.partial_code_point = CodeBits'(b[2:0]);
               st_o.bytes_remaining    = 2'd3;
            end else begin
               st_o.error_flag = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            st_o.error_flag = 1'b1;
         end else if ((3'(st_i.bytes_remaining) == st_i.sequence_length - 3'd1) &&
                      (((st_i.sequence_length == 3'd3) && (st_i.lead_byte == 8'hE0) &&
                        !b[5]) ||
                       ((st_i.sequence_length == 3'd4) && (st_i.lead_byte[2:0] == 3'd0) &&
                        (b[5:4] == 2'd0)))) begin
            // overlong three- and four-byte forms show in the first continuation
            st_o.error_flag = 1'b1;
         end else begin
            st_o.partial_code_point = {st_i.partial_code_point[CodeBits-7:0], b[5:0]};
            st_o.bytes_remaining    = st_i.bytes_remaining - 2'd1;
            finish                  = (st_i.bytes_remaining == 2'd1);
         end
      end

      if (finish) begin
         cp = st_o.partial_code_point;
         if ((cp > MaxCodePoint) || ((cp >= SurrogateLow) && (cp < SurrogateEnd))) begin
            st_o.error_flag = 1'b1;
         end else begin
            units = (cfg_i.sixteen_bit_units && (cp > 21'h00FFFF)) ? 2'd2 : 2'd1;
            if (!cfg_i.count_only &&
                ((WideBits'(written_cnt_i) + WideBits'(units)) >
                 WideBits'(cfg_i.unit_capacity))) begin
               st_o.stopped_flag = 1'b1;
            end else begin
               if (!cfg_i.count_only) begin
                  if (units == 2'd2) begin
                     sup = cp - Supplementary;
                     rsp_o[0].kind      = KIND_UNIT;
                     rsp_o[0].code_unit = SurrogateLow + CodeBits'(sup[19:10]);
                     rsp_o[1].kind      = KIND_UNIT;
                     rsp_o[1].code_unit = LowSurrogate + CodeBits'(sup[9:0]);
                     n                  = 2'd2;
                  end else begin
                     rsp_o[0].kind      = KIND_UNIT;
                     rsp_o[0].code_unit = cp;
                     n                  = 2'd1;
                  end
               end
               written_cnt_o        = sat_add(written_cnt_i, 3'(units));
               read_cnt_o           = sat_add(read_cnt_i, st_o.sequence_length);
               st_o.bytes_remaining = 2'd0;
               st_o.sequence_length = 3'd0;
            end
         end
      end

      if (end_of_string_i) begin
         if (!st_o.error_flag && !st_o.stopped_flag && (st_o.bytes_remaining != 2'd0)) begin
            st_o.error_flag = 1'b1;
         end
         if (st_o.error_flag) begin
            rsp_o[n].kind = KIND_INVALID;
         end else begin
            rd_wide                = WideBits'(read_cnt_o);
            wr_wide                = WideBits'(written_cnt_o);
            rsp_o[n].kind          = KIND_OK;
            rsp_o[n].bytes_read    = rd_wide[FieldCountBits-1:0];
            rsp_o[n].units_written = wr_wide[FieldCountBits-1:0];
         end
         n             = n + 2'd1;
         st_o          = '0;
         read_cnt_o    = '0;
         written_cnt_o = '0;
      end

      if (n != 2'd0) begin
         rsp_o[n - 2'd1].last = 1'b1;
      end
      rsp_cnt_o = n;
   end

endmodule

// ===== src/utd_rsp_queue.sv =====
module utd_rsp_queue
   import utd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_cnt_i,
   input  rsp_entry_type           push_i [MaxResults],
   input  logic                    pop_i,
   output logic [QueueCntBits-1:0] count_o,
   output rsp_entry_type           head_o
);

   rsp_entry_type           entry_ff [QueueDepth];
   logic [QueuePtrBits-1:0] wr_ptr_ff;
   logic [QueuePtrBits-1:0] wr_ptr_in;
   logic [QueuePtrBits-1:0] rd_ptr_ff;
   logic [QueuePtrBits-1:0] rd_ptr_in;
   logic [QueueCntBits-1:0] count_ff;
   logic [QueueCntBits-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QueuePtrBits'(push_cnt_i);
      rd_ptr_in = rd_ptr_ff + QueuePtrBits'(pop_i);
      count_in  = count_ff + QueueCntBits'(push_cnt_i) - QueueCntBits'(pop_i);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxResults; i++) begin
         if (i < int'(push_cnt_i)) begin
            entry_ff[wr_ptr_ff + QueuePtrBits'(i)] <= push_i[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign count_o = count_ff;
   assign head_o  = entry_ff[rd_ptr_ff];

endmodule

// ===== src/utd_checker.sv =====
module utd_checker
   import utd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RspDataBits-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser,
   input logic                   rsp_tlast
);

   // stalled beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // counts ride only on status beats
   a_unit_no_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_UNIT) |-> (rsp_tdata[RspDataBits-1:CodeBits] == '0))
      else $error("code unit beat carries counts");

   // a status always closes its input beat's group
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_UNIT) |-> rsp_tlast)
      else $error("status beat without last");

   // a high surrogate is always followed by its low half
   a_high_sur_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_UNIT) && (rsp_tdata[CodeBits-1:10] == 11'h036)
      |-> !rsp_tlast)
      else $error("high surrogate marked last");

endmodule

bind utf8_to_wide_decoder_core utd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

// ===== bench/tb_utf8_to_wide_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_utf8_to_wide_decoder_core;
   import utd_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       eos;
   } byte_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'h00;  // data_byte
   logic                   req_tuser = 1'b0;   // byte_valid
   logic                   req_tlast = 1'b0;   // end_of_string
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;  // code_unit, bytes_read, units_written, pad
   logic [1:0]             rsp_tuser;  // kind
   logic                   rsp_tlast;  // last
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CsrAddrBits-1:0] csr_paddr = '0;
   logic [31:0]            csr_pwdata = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   // decoder mirror: configuration
   logic        mode_utf16 = 1'b1;
   logic        mode_count_only = 1'b0;
   logic [23:0] unit_limit = 24'hFFFFFF;
   // decoder mirror: string state
   logic [1:0]          seq_left = '0;
   logic [2:0]          seq_len = '0;
   logic [7:0]          seq_lead = '0;
   logic [CodeBits-1:0] code_acc = '0;
   logic                conv_stopped = 1'b0;
   logic                conv_bad = 1'b0;
   logic [23:0]         bytes_done = '0;
   logic [23:0]         units_done = '0;

   byte_item_type pending_bytes[$];
   rsp_entry_type expected_units[$];
   int            beat_results = 0;
   int            mismatch_count = 0;
   logic          req_fire = 1'b0;
   logic          hold_rsp = 1'b0;
   int            send_gap_pct = 0;
   int            sink_gap_pct = 0;
   int            phase = 0;

   utf8_to_wide_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [23:0] sat_add24(logic [23:0] a, int unsigned b);
      longint sum;
      sum = longint'(a) + longint'(b);
      return (sum > 24'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
   endfunction

   function automatic void queue_result(kind_type k, logic [CodeBits-1:0] unit,
                                        logic [23:0] rd, logic [23:0] wr);
      rsp_entry_type e;
      e.kind = k;
      e.code_unit = unit;
      e.bytes_read = rd;
      e.units_written = wr;
      e.last = 1'b0;
      expected_units.push_back(e);
      beat_results++;
   endfunction

   function automatic void finish_char();
      int unsigned         units;
      logic [CodeBits-1:0] offset;
      if (code_acc > MaxCodePoint || (code_acc >= SurrogateLow && code_acc < SurrogateEnd)) begin
         conv_bad = 1'b1;
         return;
      end
      units = (mode_utf16 && code_acc > 21'h00FFFF) ? 2 : 1;
      if (!mode_count_only) begin
         if (longint'(units_done) + units > longint'(unit_limit)) begin
            conv_stopped = 1'b1;
            return;
         end
         if (units == 2) begin
            offset = code_acc - Supplementary;
            queue_result(KIND_UNIT, SurrogateLow + offset[19:10], '0, '0);
            queue_result(KIND_UNIT, LowSurrogate + offset[9:0], '0, '0);
         end else begin
            queue_result(KIND_UNIT, code_acc, '0, '0);
         end
      end
      units_done = sat_add24(units_done, units);
      bytes_done = sat_add24(bytes_done, seq_len);
      seq_left = '0;
      seq_len = '0;
   endfunction

   function automatic void decode_take(logic [7:0] b);
      if (seq_left == 0) begin
         seq_lead = b;
         if (b <= 8'h7F) begin
            seq_len = 3'd1;
            code_acc = {13'b0, b};
            finish_char();
         end else if (b[7:5] == 3'b110) begin
            // overlong two-byte form: lead C0 or C1
            if (b[4:1] == 4'b0) begin
               conv_bad = 1'b1;
            end else begin
               seq_len = 3'd2;
               code_acc = {16'b0, b[4:0]};
               seq_left = 2'd1;
            end
         end else if (b[7:4] == 4'b1110) begin
            seq_len = 3'd3;
            code_acc = {17'b0, b[3:0]};
            seq_left = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            seq_len = 3'd4;
            code_acc = {18'b0, b[2:0]};
            seq_left = 2'd3;
         end else begin
            conv_bad = 1'b1;
         end
      end else if (b[7:6] != 2'b10) begin
         conv_bad = 1'b1;
      end else if (seq_left == seq_len - 3'd1 && seq_len == 3'd3 && seq_lead == 8'hE0 && !b[5]) begin
         conv_bad = 1'b1;
      end else if (seq_left == seq_len - 3'd1 && seq_len == 3'd4 && seq_lead[2:0] == 3'b0
                   && b[5:4] == 2'b0) begin
         conv_bad = 1'b1;
      end else begin
         code_acc = {code_acc[14:0], b[5:0]};
         seq_left = seq_left - 2'd1;
         if (seq_left == 0) finish_char();
      end
   endfunction

   function automatic void decode_beat(logic [7:0] data, logic valid, logic eos);
      rsp_entry_type tail;
      beat_results = 0;
      if (valid && !conv_bad && !conv_stopped) decode_take(data);
      if (eos) begin
         // a sequence cut short by the end marker is invalid
         if (!conv_bad && !conv_stopped && seq_left != 0) conv_bad = 1'b1;
         if (conv_bad) queue_result(KIND_INVALID, '0, '0, '0);
         else queue_result(KIND_OK, '0, bytes_done, units_done);
         seq_left = '0;
         seq_len = '0;
         seq_lead = '0;
         code_acc = '0;
         conv_stopped = 1'b0;
         conv_bad = 1'b0;
         bytes_done = '0;
         units_done = '0;
      end
      if (beat_results > 0) begin
         tail = expected_units.pop_back();
         tail.last = 1'b1;
         expected_units.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------- driver and monitor

   always @(negedge clock) begin
      byte_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_bytes.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
            item = pending_bytes.pop_front();
            req_tdata <= item.data;
            req_tuser <= item.valid;
            req_tlast <= item.eos;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= sink_gap_pct);
   end

   function automatic void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_entry_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) decode_beat(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_units.size() == 0) begin
               $display("%0t: unexpected beat: expected none, got kind %0d unit %h",
                        $time, rsp_tuser, rsp_tdata[20:0]);
               mismatch_count++;
            end else begin
               want = expected_units.pop_front();
               compare_field("kind", want.kind, rsp_tuser);
               compare_field("code_unit", want.code_unit, rsp_tdata[20:0]);
               compare_field("bytes_read", want.bytes_read, rsp_tdata[44:21]);
               compare_field("units_written", want.units_written, rsp_tdata[68:45]);
               compare_field("pad", '0, rsp_tdata[71:69]);
               compare_field("last", want.last, rsp_tlast);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void push_item(logic [7:0] data, logic valid, logic eos);
      byte_item_type item;
      item.data = data;
      item.valid = valid;
      item.eos = eos;
      pending_bytes.push_back(item);
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   // encode a code point; drop its final byte to cut the sequence short
   function automatic void push_char(logic [20:0] cp, bit cut);
      logic [7:0] seq [4];
      int         len;
      if (cp < 21'h80) begin
         seq[0] = cp[7:0];
         len = 1;
      end else if (cp < 21'h800) begin
         seq[0] = {3'b110, cp[10:6]};
         seq[1] = {2'b10, cp[5:0]};
         len = 2;
      end else if (cp < 21'h10000) begin
         seq[0] = {4'b1110, cp[15:12]};
         seq[1] = {2'b10, cp[11:6]};
         seq[2] = {2'b10, cp[5:0]};
         len = 3;
      end else begin
         seq[0] = {5'b11110, cp[20:18]};
         seq[1] = {2'b10, cp[17:12]};
         seq[2] = {2'b10, cp[11:6]};
         seq[3] = {2'b10, cp[5:0]};
         len = 4;
      end
      if (cut && len > 1) len--;
      for (int i = 0; i < len; i++) push_item(seq[i], 1'b1, 1'b0);
   endfunction

   function automatic void push_malformed();
      case ($urandom_range(0, 7))
         0: begin
            push_item(8'($urandom_range(8'hC0, 8'hC1)), 1'b1, 1'b0);
            push_item(cont_byte(), 1'b1, 1'b0);
         end
         1: begin
            push_item(8'hE0, 1'b1, 1'b0);
            push_item(8'($urandom_range(8'h80, 8'h9F)), 1'b1, 1'b0);
            push_item(cont_byte(), 1'b1, 1'b0);
         end
         2: begin
            push_item(8'hF0, 1'b1, 1'b0);
            push_item(8'($urandom_range(8'h80, 8'h8F)), 1'b1, 1'b0);
            push_item(cont_byte(), 1'b1, 1'b0);
            push_item(cont_byte(), 1'b1, 1'b0);
         end
         3: begin
            push_item(8'hF4, 1'b1, 1'b0);
            push_item(8'($urandom_range(8'h90, 8'hBF)), 1'b1, 1'b0);
            push_item(cont_byte(), 1'b1, 1'b0);
            push_item(cont_byte(), 1'b1, 1'b0);
         end
         4: begin
            push_item(8'($urandom_range(8'hF5, 8'hF7)), 1'b1, 1'b0);
            push_item(cont_byte(), 1'b1, 1'b0);
            push_item(cont_byte(), 1'b1, 1'b0);
            push_item(cont_byte(), 1'b1, 1'b0);
         end
         5: push_item(8'($urandom_range(8'hF8, 8'hFF)), 1'b1, 1'b0);
         6: push_item(cont_byte(), 1'b1, 1'b0);
         default: begin
            push_item(8'($urandom_range(8'hC2, 8'hF4)), 1'b1, 1'b0);
            push_item(8'($urandom_range(0, 8'h7F)), 1'b1, 1'b0);
         end
      endcase
   endfunction

   function automatic void push_random_char(bit cut);
      case ($urandom_range(0, 9))
         0, 1, 2: push_char(21'($urandom_range(0, 'h7F)), cut);
         3:       push_char(21'($urandom_range('h80, 'h7FF)), cut);
         4, 5:    push_char(21'($urandom_range('h800, 'hFFFF)), cut);
         6, 7:    push_char(21'($urandom_range('h10000, 'h10FFFF)), cut);
         8:       push_malformed();
         default: push_item(8'($urandom), 1'b1, 1'b0);
      endcase
   endfunction

   function automatic void push_random_string();
      int            chars;
      bit            cut;
      byte_item_type tail;
      chars = $urandom_range(0, 6);
      cut = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      for (int i = 0; i < chars; i++) push_random_char(cut && i == chars - 1);
      if (chars > 0 && !cut && $urandom_range(0, 1) == 1) begin
         tail = pending_bytes.pop_back();
         tail.eos = 1'b1;
         pending_bytes.push_back(tail);
      end else begin
         push_item(8'($urandom), 1'b0, 1'b1);
      end
   endfunction

   function automatic void push_random_strings(int count);
      int target;
      target = pending_bytes.size() + count;
      while (pending_bytes.size() < target) push_random_string();
   endfunction

   function automatic void push_directed();
      // ASCII low, two-byte top, three-byte bottom, four-byte bottom with status
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hDF, 1'b1, 1'b0);
      push_item(8'hBF, 1'b1, 1'b0);
      push_item(8'hE0, 1'b1, 1'b0);
      push_item(8'hA0, 1'b1, 1'b0);
      push_item(8'h80, 1'b1, 1'b0);
      push_item(8'hF0, 1'b1, 1'b0);
      push_item(8'h90, 1'b1, 1'b0);
      push_item(8'h80, 1'b1, 1'b0);
      push_item(8'h80, 1'b1, 1'b1);
      // ASCII top, highest code point
      push_item(8'h7F, 1'b1, 1'b0);
      push_item(8'hF4, 1'b1, 1'b0);
      push_item(8'h8F, 1'b1, 1'b0);
      push_item(8'hBF, 1'b1, 1'b0);
      push_item(8'hBF, 1'b1, 1'b1);
      // overlong two-byte lead
      push_item(8'hC1, 1'b1, 1'b1);
      // encoded surrogate
      push_item(8'hED, 1'b1, 1'b0);
      push_item(8'hA0, 1'b1, 1'b0);
      push_item(8'h80, 1'b1, 1'b1);
      // lead above the code space
      push_item(8'hF5, 1'b1, 1'b1);
      // truncated at the end marker
      push_item(8'hE2, 1'b1, 1'b0);
      push_item(8'h82, 1'b1, 1'b0);
      push_item(8'h5A, 1'b0, 1'b1);
      // empty item, then an illegal byte
      push_item(8'hA5, 1'b0, 1'b0);
      push_item(8'hFF, 1'b1, 1'b1);
   endfunction

   // ---------------------------------------------------------------- sequencing

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         RegSixteenBitUnits: mode_utf16 = value[0];
         RegCountOnly:       mode_count_only = value[0];
         RegUnitCapacity:    unit_limit = value[23:0];
         default: ;
      endcase
   endtask

   task automatic set_mode(logic utf16, logic count_only, logic [23:0] capacity,
                           int send_gap, int sink_gap);
      write_reg(RegSixteenBitUnits, {31'b0, utf16});
      write_reg(RegCountOnly, {31'b0, count_only});
      write_reg(RegUnitCapacity, {8'b0, capacity});
      send_gap_pct = send_gap;
      sink_gap_pct = sink_gap;
      phase++;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid || expected_units.size() != 0)
         @(posedge clock);
      // let items that produce nothing settle before the next register write
      repeat (6) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_mode(1'b1, 1'b0, 24'hFFFFFF, 18, 78);
      push_directed();
      push_random_strings(40);
      wait_drained();

      set_mode(1'b0, 1'b0, 24'($urandom_range(3, 12)), 78, 18);
      push_random_strings(45);
      wait_drained();

      // receiver holds off during this phase so the result queue backs up
      set_mode(1'b1, 1'b0, 24'hFFFFFF, 0, 0);
      push_random_strings(50);
      wait_drained();

      set_mode(1'b1, 1'b1, 24'h000000, 0, 0);
      push_random_strings(35);
      wait_drained();

      set_mode(1'b1, 1'b0, 24'h000000, 0, 0);
      push_random_strings(25);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      wait (phase == 3);
      repeat (20) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (120) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
src/utd_pkg.sv
src/utd_step.sv
src/utd_rsp_queue.sv
src/utf8_to_wide_decoder_core.sv
src/utd_checker.sv
bench/tb_utf8_to_wide_decoder_core.sv
